[rtl/core/rmpd_pkg.sv]
// rmpd_pkg: types, codes and constants shared by the rumble motor pulse driver
// no dependencies
package rmpd_pkg;

  // minimum payload byte count for a report
  localparam int unsigned REPORT_BYTES = 8;

  // action codes
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_REPORT = 2'd1;
  localparam logic [1:0] ACT_STOP   = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STRENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FRAMES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAMES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_STEP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KICK_LENGTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_ON_LEVEL  = 3'd6;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration reset values
  localparam logic [7:0]  RST_MIN_STRENGTH   = 8'd96;
  localparam logic [15:0] RST_DEFAULT_FRAMES = 16'd18;
  localparam logic [15:0] RST_MIN_FRAMES     = 16'd4;
  localparam logic [7:0]  RST_RISE_STEP      = 8'd32;
  localparam logic [7:0]  RST_FALL_STEP      = 8'd48;
  localparam logic [1:0]  RST_KICK_LENGTH    = 2'd2;
  localparam logic [7:0]  RST_FULL_ON_LEVEL  = 8'd248;

  localparam logic [15:0] CONTINUOUS_FRAMES = 16'hffff;
  localparam logic [15:0] MAX_FRAMES        = 16'hfffe;
  localparam logic [7:0]  KICK_THRESHOLD    = 8'd96;
  localparam logic [7:0]  PERCENT_MAX       = 8'd100;
  localparam logic [7:0]  DUR_CONTINUOUS    = 8'd255;

  // floor(y / 100) = (y * PCT_RECIP) >> PCT_SHIFT for y below 43690
  localparam logic [14:0] PCT_RECIP = 15'd20972;
  localparam int unsigned PCT_SHIFT = 21;
  // floor(x / 5) = (x * FIVE_RECIP) >> FIVE_SHIFT for x below 2**18
  localparam logic [17:0] FIVE_RECIP = 18'd209716;
  localparam int unsigned FIVE_SHIFT = 20;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] control_byte;
    logic [7:0] magnitude_a;
    logic [7:0] magnitude_b;
    logic [7:0] magnitude_c;
    logic [7:0] magnitude_d;
    logic [7:0] duration_units;
    logic [7:0] repeat_count;
    logic [7:0] payload_length;
  } in_t;

  typedef struct packed {
    logic       motor_on;
    logic       report_accepted;
    logic [7:0] drive_level;
  } out_t;

  typedef struct packed {
    logic [7:0]  min_strength;
    logic [15:0] default_frames;
    logic [15:0] min_frames;
    logic [7:0]  rise_step;
    logic [7:0]  fall_step;
    logic [1:0]  kick_length;
    logic [7:0]  full_on_level;
  } cfg_t;

  // decoded word held in the input register
  typedef struct packed {
    logic [1:0]  action;
    logic        long_enough;
    logic        enable_nz;
    logic        mag_nz;
    logic [7:0]  scaled;
    logic        continuous;
    logic        dur_zero;
    logic [15:0] total;
  } prep_t;

endpackage

[rtl/core/rumble_motor_pulse_driver.sv]
// rumble_motor_pulse_driver: top level with input register, result register
// and configuration registers; uses rmpd_pkg, rmpd_prep, rmpd_core
//
//   channel   handshake                    word / data
//   in        in_valid_i / in_ready_o      in_word_i   (rmpd_pkg::in_t)
//   out       out_valid_o / out_ready_i    out_word_o  (rmpd_pkg::out_t)
//   cfg       cfg_we_i (no wait)           cfg_idx_i, cfg_wdata_i
//
// one word per cycle sustained while the output is not stalled; a word's result
// passes through the input register, then the state update that loads the result
// register
// reset sets the configuration to its defaults and clears all drive state
// a stalled output holds its word; the input register keeps filling behind it,
// so up to two words are held before in_ready_o drops
module rumble_motor_pulse_driver (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rmpd_pkg::in_t                       in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rmpd_pkg::out_t                      out_word_o,
  input  logic                                cfg_we_i,
  input  logic [rmpd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rmpd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  rmpd_pkg::cfg_t  cfg_q;
  rmpd_pkg::prep_t prep;
  rmpd_pkg::prep_t s1_q;
  rmpd_pkg::out_t  result;
  rmpd_pkg::out_t  out_q;
  logic            s1_valid_q;
  logic            out_valid_q;
  logic            advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_strength   <= rmpd_pkg::RST_MIN_STRENGTH;
      cfg_q.default_frames <= rmpd_pkg::RST_DEFAULT_FRAMES;
      cfg_q.min_frames     <= rmpd_pkg::RST_MIN_FRAMES;
      cfg_q.rise_step      <= rmpd_pkg::RST_RISE_STEP;
      cfg_q.fall_step      <= rmpd_pkg::RST_FALL_STEP;
      cfg_q.kick_length    <= rmpd_pkg::RST_KICK_LENGTH;
      cfg_q.full_on_level  <= rmpd_pkg::RST_FULL_ON_LEVEL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rmpd_pkg::CFG_MIN_STRENGTH:   cfg_q.min_strength   <= cfg_wdata_i[7:0];
        rmpd_pkg::CFG_DEFAULT_FRAMES: cfg_q.default_frames <= cfg_wdata_i;
        rmpd_pkg::CFG_MIN_FRAMES:     cfg_q.min_frames     <= cfg_wdata_i;
        rmpd_pkg::CFG_RISE_STEP:      cfg_q.rise_step      <= cfg_wdata_i[7:0];
        rmpd_pkg::CFG_FALL_STEP:      cfg_q.fall_step      <= cfg_wdata_i[7:0];
        rmpd_pkg::CFG_KICK_LENGTH:    cfg_q.kick_length    <= cfg_wdata_i[1:0];
        rmpd_pkg::CFG_FULL_ON_LEVEL:  cfg_q.full_on_level  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  rmpd_prep u_prep (
    .in_word_i (in_word_i),
    .prep_o    (prep)
  );

  // the held word moves on whenever the result register is free or drains
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= prep;
    end
  end

  rmpd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (s1_q),
    .step_i   (advance),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // a stop always leaves an all-zero result
  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_q.action == rmpd_pkg::ACT_STOP
    |=> out_valid_o && out_word_o.motor_on == 1'b0 &&
        out_word_o.report_accepted == 1'b0 && out_word_o.drive_level == 8'd0)
    else $error("stop did not clear drive state");

  // only report words can carry an accepted flag
  a_accept_only_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_q.action != rmpd_pkg::ACT_REPORT |=> !out_word_o.report_accepted)
    else $error("accepted flag on a non-report word");

  // input backpressure only when both registers are occupied and the output stalls
  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  // a report with an enable bit and a nonzero magnitude does not move the level
  a_report_holds_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_q.action == rmpd_pkg::ACT_REPORT && s1_q.enable_nz && s1_q.mag_nz
    && $past(advance) |=> out_word_o.drive_level == $past(out_q.drive_level))
    else $error("report changed the drive level");

endmodule

[rtl/core/rmpd_prep.sv]
// rmpd_prep: decodes an incoming word ahead of the input register
// (largest magnitude, percent scaling, duration times loop count); uses rmpd_pkg
module rmpd_prep (
  input  rmpd_pkg::in_t   in_word_i,
  output rmpd_pkg::prep_t prep_o
);

  logic [7:0]  max_ab, max_cd, mag;
  logic [15:0] pct_y;
  logic [29:0] pct_prod;
  logic [7:0]  pct_val;
  logic [7:0]  loops_eff;

  assign max_ab = (in_word_i.magnitude_b > in_word_i.magnitude_a) ?
                  in_word_i.magnitude_b : in_word_i.magnitude_a;
  assign max_cd = (in_word_i.magnitude_d > in_word_i.magnitude_c) ?
                  in_word_i.magnitude_d : in_word_i.magnitude_c;
  assign mag    = (max_cd > max_ab) ? max_cd : max_ab;

  // round(mag * 255 / 100)
  assign pct_y    = {mag, 8'd0} - {8'd0, mag} + 16'd50;
  assign pct_prod = {15'd0, pct_y[14:0]} * {15'd0, rmpd_pkg::PCT_RECIP};
  assign pct_val  = pct_prod[rmpd_pkg::PCT_SHIFT +: 8];

  assign loops_eff = (in_word_i.repeat_count == 8'd0) ? 8'd1 : in_word_i.repeat_count;

  always_comb begin
    prep_o.action      = in_word_i.action;
    prep_o.long_enough = in_word_i.payload_length >= 8'(rmpd_pkg::REPORT_BYTES);
    prep_o.enable_nz   = in_word_i.control_byte[3:0] != 4'd0;
    prep_o.mag_nz      = mag != 8'd0;
    prep_o.scaled      = (mag <= rmpd_pkg::PERCENT_MAX) ? pct_val : mag;
    prep_o.continuous  = (in_word_i.duration_units == rmpd_pkg::DUR_CONTINUOUS) ||
                         (in_word_i.repeat_count == rmpd_pkg::DUR_CONTINUOUS);
    prep_o.dur_zero    = in_word_i.duration_units == 8'd0;
    prep_o.total       = {8'd0, in_word_i.duration_units} * {8'd0, loops_eff};
  end

endmodule

[rtl/core/rmpd_core.sv]
// rmpd_core: drive state (target, slewed level, modulator, kick, frame count, pin)
// and the per-word step logic; uses rmpd_pkg
module rmpd_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rmpd_pkg::cfg_t  cfg_i,
  input  rmpd_pkg::prep_t item_i,
  input  logic            step_i,
  output rmpd_pkg::out_t  result_o
);

  logic [7:0]  target_q, target_d;
  logic [7:0]  present_q, present_d;
  logic [7:0]  acc_q, acc_d;
  logic [1:0]  kick_q, kick_d;
  logic [15:0] frames_q, frames_d;
  logic        pin_q, pin_d;
  logic        accepted;

  // report frame count: ceil(total * 60 / 100) = floor((3 * total + 4) / 5)
  logic [17:0] five_x;
  logic [35:0] five_prod;
  logic [15:0] calc_frames, clamp_lo, clamp_frames, rep_frames;
  logic [7:0]  strength;
  logic [7:0]  tick_target, slew_diff;
  logic [8:0]  acc_sum;

  assign five_x       = {2'd0, item_i.total} + {1'b0, item_i.total, 1'b0} + 18'd4;
  assign five_prod    = {18'd0, five_x} * {18'd0, rmpd_pkg::FIVE_RECIP};
  assign calc_frames  = five_prod[rmpd_pkg::FIVE_SHIFT +: 16];
  assign clamp_lo     = (calc_frames < cfg_i.min_frames) ? cfg_i.min_frames : calc_frames;
  assign clamp_frames = (clamp_lo > rmpd_pkg::MAX_FRAMES) ? rmpd_pkg::MAX_FRAMES : clamp_lo;

  always_comb begin
    priority if (item_i.continuous) begin
      rep_frames = rmpd_pkg::CONTINUOUS_FRAMES;
    end else if (!item_i.dur_zero) begin
      rep_frames = clamp_frames;
    end else begin
      rep_frames = cfg_i.default_frames;
    end
  end

  assign strength = (item_i.scaled != 8'd0 && item_i.scaled < cfg_i.min_strength) ?
                    cfg_i.min_strength : item_i.scaled;

  always_comb begin
    target_d    = target_q;
    present_d   = present_q;
    acc_d       = acc_q;
    kick_d      = kick_q;
    frames_d    = frames_q;
    pin_d       = pin_q;
    accepted    = 1'b0;
    tick_target = target_q;
    slew_diff   = 8'd0;
    acc_sum     = {1'b0, acc_q} + {1'b0, present_q};
    unique case (item_i.action)
      rmpd_pkg::ACT_TICK: begin
        if (frames_q != 16'd0 && frames_q != rmpd_pkg::CONTINUOUS_FRAMES) begin
          frames_d = frames_q - 16'd1;
          if (frames_q == 16'd1) begin
            tick_target = 8'd0;
          end
        end
        target_d = tick_target;
        if (present_q < tick_target) begin
          slew_diff = tick_target - present_q;
          present_d = present_q + ((slew_diff > cfg_i.rise_step) ? cfg_i.rise_step : slew_diff);
        end else if (present_q > tick_target) begin
          slew_diff = present_q - tick_target;
          present_d = present_q - ((slew_diff > cfg_i.fall_step) ? cfg_i.fall_step : slew_diff);
        end
        acc_sum = {1'b0, acc_q} + {1'b0, present_d};
        priority if (present_d >= cfg_i.full_on_level) begin
          pin_d = 1'b1;
        end else if (present_d != 8'd0) begin
          if (kick_q != 2'd0) begin
            kick_d = kick_q - 2'd1;
            pin_d  = 1'b1;
          end else begin
            acc_d = acc_sum[7:0];
            pin_d = acc_sum[8];
          end
        end else begin
          pin_d = 1'b0;
        end
      end
      rmpd_pkg::ACT_REPORT: begin
        if (item_i.long_enough) begin
          accepted = 1'b1;
          if (!item_i.enable_nz || !item_i.mag_nz || strength == 8'd0) begin
            // silent or disabled report halts everything
            target_d  = 8'd0;
            present_d = 8'd0;
            acc_d     = 8'd0;
            kick_d    = 2'd0;
            frames_d  = 16'd0;
            pin_d     = 1'b0;
          end else begin
            target_d = strength;
            frames_d = rep_frames;
            if (strength > present_q && strength >= rmpd_pkg::KICK_THRESHOLD) begin
              kick_d = cfg_i.kick_length;
            end
          end
        end
      end
      rmpd_pkg::ACT_STOP: begin
        target_d  = 8'd0;
        present_d = 8'd0;
        acc_d     = 8'd0;
        kick_d    = 2'd0;
        frames_d  = 16'd0;
        pin_d     = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= 8'd0;
      present_q <= 8'd0;
      acc_q     <= 8'd0;
      kick_q    <= 2'd0;
      frames_q  <= 16'd0;
      pin_q     <= 1'b0;
    end else if (step_i) begin
      target_q  <= target_d;
      present_q <= present_d;
      acc_q     <= acc_d;
      kick_q    <= kick_d;
      frames_q  <= frames_d;
      pin_q     <= pin_d;
    end
  end

  assign result_o.motor_on        = pin_d;
  assign result_o.report_accepted = accepted;
  assign result_o.drive_level     = present_d;

endmodule

[sim/rmpd_result_check.sv]
// rmpd_result_check: watches the word, result and register ports of the rumble motor
// pulse driver, predicts each result word and compares it field by field; uses rmpd_pkg
`timescale 1ns / 100ps
module rmpd_result_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  rmpd_pkg::in_t                   in_word_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  rmpd_pkg::out_t                  out_word_i,
  input  logic                            cfg_we_i,
  input  logic [rmpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rmpd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic [31:0]                     fail_count_o,
  output logic [31:0]                     pending_o
);

  localparam logic [7:0] LOOP_CONTINUOUS = 8'hff;

  rmpd_pkg::cfg_t  cfg;
  logic [7:0]      target_lvl;
  logic [7:0]      drive_lvl;
  logic [7:0]      pulse_acc;
  logic [1:0]      kick_left;
  logic [15:0]     frame_budget;
  logic            pin;
  rmpd_pkg::out_t  drive_results_q[$];
  rmpd_pkg::out_t  want;
  rmpd_pkg::out_t  next_word;
  logic            taken;

  function automatic void clear_drive();
    target_lvl   = '0;
    drive_lvl    = '0;
    pulse_acc    = '0;
    kick_left    = '0;
    frame_budget = '0;
    pin          = 1'b0;
  endfunction

  function automatic logic [7:0] scale_strength(input logic [7:0] mag);
    int unsigned s;
    s = 32'(mag);
    if (mag <= rmpd_pkg::PERCENT_MAX) s = (s * 32'd255 + 32'd50) / 32'd100;
    if (s != 32'd0 && s < 32'(cfg.min_strength)) s = 32'(cfg.min_strength);
    return s[7:0];
  endfunction

  function automatic void apply_tick();
    int unsigned acc;
    logic        on;
    on = 1'b0;
    if (frame_budget != 16'd0 && frame_budget != rmpd_pkg::CONTINUOUS_FRAMES) begin
      frame_budget = frame_budget - 16'd1;
      if (frame_budget == 16'd0) target_lvl = '0;
    end
    if (drive_lvl < target_lvl) begin
      if (target_lvl - drive_lvl > cfg.rise_step) drive_lvl = drive_lvl + cfg.rise_step;
      else drive_lvl = target_lvl;
    end else if (drive_lvl > target_lvl) begin
      if (drive_lvl - target_lvl > cfg.fall_step) drive_lvl = drive_lvl - cfg.fall_step;
      else drive_lvl = target_lvl;
    end
    if (drive_lvl >= cfg.full_on_level) begin
      on = 1'b1;
    end else if (drive_lvl != 8'd0) begin
      if (kick_left != 2'd0) begin
        kick_left = kick_left - 2'd1;
        on = 1'b1;
      end else begin
        // density modulator: carry out of the accumulator fires the pin
        acc = 32'(pulse_acc);
        acc = acc + 32'(drive_lvl);
        pulse_acc = acc[7:0];
        on = (acc >= 32'd256);
      end
    end
    pin = on;
  endfunction

  function automatic logic apply_report(input rmpd_pkg::in_t w);
    logic [7:0]  peak;
    logic [7:0]  strength;
    logic [15:0] frames;
    int unsigned total;
    int unsigned span;
    if (w.payload_length < 8'(rmpd_pkg::REPORT_BYTES)) return 1'b0;
    peak = w.magnitude_a;
    if (w.magnitude_b > peak) peak = w.magnitude_b;
    if (w.magnitude_c > peak) peak = w.magnitude_c;
    if (w.magnitude_d > peak) peak = w.magnitude_d;
    if (w.control_byte[3:0] == 4'h0 || peak == 8'd0) begin
      clear_drive();
      return 1'b1;
    end
    if (w.duration_units == rmpd_pkg::DUR_CONTINUOUS ||
        w.repeat_count == LOOP_CONTINUOUS) begin
      frames = rmpd_pkg::CONTINUOUS_FRAMES;
    end else if (w.duration_units != 8'd0) begin
      total = 32'(w.duration_units);
      if (w.repeat_count != 8'd0) total = total * 32'(w.repeat_count);
      // 10 ms units to frames, rounded up
      span = (total * 32'd60 + 32'd99) / 32'd100;
      if (span < 32'(cfg.min_frames)) span = 32'(cfg.min_frames);
      if (span > 32'(rmpd_pkg::MAX_FRAMES)) span = 32'(rmpd_pkg::MAX_FRAMES);
      frames = span[15:0];
    end else begin
      frames = cfg.default_frames;
    end
    strength = scale_strength(peak);
    if (strength == 8'd0) begin
      clear_drive();
      return 1'b1;
    end
    target_lvl   = strength;
    frame_budget = frames;
    if (strength > drive_lvl && strength >= rmpd_pkg::KICK_THRESHOLD)
      kick_left = cfg.kick_length;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.min_strength   = rmpd_pkg::RST_MIN_STRENGTH;
      cfg.default_frames = rmpd_pkg::RST_DEFAULT_FRAMES;
      cfg.min_frames     = rmpd_pkg::RST_MIN_FRAMES;
      cfg.rise_step      = rmpd_pkg::RST_RISE_STEP;
      cfg.fall_step      = rmpd_pkg::RST_FALL_STEP;
      cfg.kick_length    = rmpd_pkg::RST_KICK_LENGTH;
      cfg.full_on_level  = rmpd_pkg::RST_FULL_ON_LEVEL;
      clear_drive();
      drive_results_q.delete();
      fail_count_o = '0;
      pending_o    = '0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (drive_results_q.size() == 0) begin
          $display("%0t: result word with none pending: motor_on %0d accepted %0d level %0d",
                   $time, out_word_i.motor_on, out_word_i.report_accepted,
                   out_word_i.drive_level);
          fail_count_o = fail_count_o + 32'd1;
        end else begin
          want = drive_results_q.pop_front();
          if (out_word_i.motor_on !== want.motor_on) begin
            $display("%0t: motor_on mismatch, expected %0d, got %0d",
                     $time, want.motor_on, out_word_i.motor_on);
            fail_count_o = fail_count_o + 32'd1;
          end
          if (out_word_i.report_accepted !== want.report_accepted) begin
            $display("%0t: report_accepted mismatch, expected %0d, got %0d",
                     $time, want.report_accepted, out_word_i.report_accepted);
            fail_count_o = fail_count_o + 32'd1;
          end
          if (out_word_i.drive_level !== want.drive_level) begin
            $display("%0t: drive_level mismatch, expected %0d, got %0d",
                     $time, want.drive_level, out_word_i.drive_level);
            fail_count_o = fail_count_o + 32'd1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        taken = 1'b0;
        case (in_word_i.action)
          rmpd_pkg::ACT_TICK:   apply_tick();
          rmpd_pkg::ACT_REPORT: taken = apply_report(in_word_i);
          rmpd_pkg::ACT_STOP:   clear_drive();
          default: ;
        endcase
        next_word.motor_on        = pin;
        next_word.report_accepted = taken;
        next_word.drive_level     = drive_lvl;
        drive_results_q.push_back(next_word);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rmpd_pkg::CFG_MIN_STRENGTH:   cfg.min_strength   = cfg_wdata_i[7:0];
          rmpd_pkg::CFG_DEFAULT_FRAMES: cfg.default_frames = cfg_wdata_i;
          rmpd_pkg::CFG_MIN_FRAMES:     cfg.min_frames     = cfg_wdata_i;
          rmpd_pkg::CFG_RISE_STEP:      cfg.rise_step      = cfg_wdata_i[7:0];
          rmpd_pkg::CFG_FALL_STEP:      cfg.fall_step      = cfg_wdata_i[7:0];
          rmpd_pkg::CFG_KICK_LENGTH:    cfg.kick_length    = cfg_wdata_i[1:0];
          rmpd_pkg::CFG_FULL_ON_LEVEL:  cfg.full_on_level  = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      pending_o = 32'(drive_results_q.size());
    end
  end

endmodule

[sim/rumble_motor_pulse_driver_tb.sv]
// rumble_motor_pulse_driver_tb: drives ticks, rumble reports and stops into the driver
// under several register settings; uses rmpd_pkg, rmpd_result_check and the RTL
`timescale 1ns / 100ps
module rumble_motor_pulse_driver_tb;

  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned PHASE_WORDS = 125;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 4;
  localparam logic [7:0]  FULL_LEN    = 8'(rmpd_pkg::REPORT_BYTES);

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  rmpd_pkg::in_t                   in_word_i   = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  rmpd_pkg::out_t                  out_word_o;
  logic                            cfg_we_i    = 1'b0;
  logic [rmpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [rmpd_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic [31:0]                     fail_count;
  logic [31:0]                     pending_words;
  logic                            calm        = 1'b0;
  int unsigned                     ready_run   = 0;
  int unsigned                     quiet_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rumble_motor_pulse_driver uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  rmpd_result_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_i   (out_word_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] random_magnitude();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'd0;
    if (r < 55) return 8'($urandom_range(1, 100));
    if (r < 65) return 8'($urandom_range(99, 102));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic rmpd_pkg::in_t plain_word(input logic [1:0] act);
    rmpd_pkg::in_t w;
    w.action         = act;
    w.control_byte   = 8'($urandom_range(0, 255));
    w.magnitude_a    = 8'($urandom_range(0, 255));
    w.magnitude_b    = 8'($urandom_range(0, 255));
    w.magnitude_c    = 8'($urandom_range(0, 255));
    w.magnitude_d    = 8'($urandom_range(0, 255));
    w.duration_units = 8'($urandom_range(0, 255));
    w.repeat_count   = 8'($urandom_range(0, 255));
    w.payload_length = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic rmpd_pkg::in_t report_word(input logic [7:0] ctl, input logic [7:0] a,
                                                input logic [7:0] b, input logic [7:0] c,
                                                input logic [7:0] d, input logic [7:0] dur,
                                                input logic [7:0] loops,
                                                input logic [7:0] len);
    rmpd_pkg::in_t w;
    w.action         = rmpd_pkg::ACT_REPORT;
    w.control_byte   = ctl;
    w.magnitude_a    = a;
    w.magnitude_b    = b;
    w.magnitude_c    = c;
    w.magnitude_d    = d;
    w.duration_units = dur;
    w.repeat_count   = loops;
    w.payload_length = len;
    return w;
  endfunction

  function automatic rmpd_pkg::in_t random_report();
    rmpd_pkg::in_t w;
    int unsigned   r;
    w = plain_word(rmpd_pkg::ACT_REPORT);
    if ($urandom_range(0, 9) == 0) w.control_byte[3:0] = 4'h0;
    w.magnitude_a = random_magnitude();
    w.magnitude_b = random_magnitude();
    w.magnitude_c = random_magnitude();
    w.magnitude_d = random_magnitude();
    if ($urandom_range(0, 19) == 0) begin
      w.magnitude_a = '0;
      w.magnitude_b = '0;
      w.magnitude_c = '0;
      w.magnitude_d = '0;
    end
    r = $urandom_range(0, 99);
    if (r < 15) w.duration_units = 8'd0;
    else if (r < 25) w.duration_units = 8'hff;
    else if (r < 75) w.duration_units = 8'($urandom_range(1, 12));
    r = $urandom_range(0, 99);
    if (r < 30) w.repeat_count = 8'd0;
    else if (r < 38) w.repeat_count = 8'hff;
    else if (r < 80) w.repeat_count = 8'($urandom_range(1, 4));
    if ($urandom_range(0, 9) == 0)
      w.payload_length = 8'($urandom_range(0, rmpd_pkg::REPORT_BYTES - 1));
    else w.payload_length = 8'($urandom_range(rmpd_pkg::REPORT_BYTES, 255));
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input rmpd_pkg::in_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [rmpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rmpd_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  task automatic set_config(input rmpd_pkg::cfg_t c);
    wait_drained();
    write_reg(rmpd_pkg::CFG_MIN_STRENGTH, {8'd0, c.min_strength});
    write_reg(rmpd_pkg::CFG_DEFAULT_FRAMES, c.default_frames);
    write_reg(rmpd_pkg::CFG_MIN_FRAMES, c.min_frames);
    write_reg(rmpd_pkg::CFG_RISE_STEP, {8'd0, c.rise_step});
    write_reg(rmpd_pkg::CFG_FALL_STEP, {8'd0, c.fall_step});
    write_reg(rmpd_pkg::CFG_KICK_LENGTH, {14'd0, c.kick_length});
    write_reg(rmpd_pkg::CFG_FULL_ON_LEVEL, {8'd0, c.full_on_level});
    cfg_we_i <= 1'b0;
  endtask

  // receiver: ready runs and stalls of random length
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (ready_run != 0) begin
      ready_run = ready_run - 1;
    end else if (out_ready_i) begin
      ready_run = pick_gap();
      if (ready_run != 0) begin
        out_ready_i <= 1'b0;
        ready_run = ready_run - 1;
      end else begin
        ready_run = $urandom_range(1, 8);
      end
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 9) == 0) ready_run = $urandom_range(40, 150);
      else ready_run = $urandom_range(0, 12);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rmpd_pkg::cfg_t c;
    rmpd_pkg::in_t  w;
    int unsigned    words;
    int unsigned    issued;
    int unsigned    r;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at reset register values
    send_word(plain_word(rmpd_pkg::ACT_TICK));
    // one byte short, then empty payload
    send_word(report_word(8'h0f, 8'd200, 8'd0, 8'd0, 8'd0, 8'd10, 8'd0, FULL_LEN - 8'd1));
    send_word(report_word(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'd10, 8'd0, 8'd0));
    send_word(plain_word(ACT_UNUSED));
    // enable nibble clear, then all magnitudes zero
    send_word(report_word(8'hf0, 8'd200, 8'd0, 8'd0, 8'd0, 8'd10, 8'd0, FULL_LEN));
    send_word(report_word(8'h0f, 8'd0, 8'd0, 8'd0, 8'd0, 8'd10, 8'd0, FULL_LEN));
    // continuous full strength with kick
    send_word(report_word(8'h01, 8'd0, 8'd0, 8'd0, 8'hff, 8'hff, 8'd0, FULL_LEN));
    repeat (5) send_word(plain_word(rmpd_pkg::ACT_TICK));
    // percent value, short timed effect that runs out
    send_word(report_word(8'h02, 8'd50, 8'd0, 8'd20, 8'd0, 8'd3, 8'd2, 8'hff));
    repeat (4) send_word(plain_word(rmpd_pkg::ACT_TICK));
    // tiny magnitude raised to the floor, looping forever
    send_word(report_word(8'h04, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'hff, FULL_LEN));
    // just above percent range, long timed effect
    send_word(report_word(8'h08, 8'd0, 8'd0, 8'd100, 8'd101, 8'hfe, 8'hfe, 8'd16));
    send_word(plain_word(rmpd_pkg::ACT_TICK));
    send_word(plain_word(rmpd_pkg::ACT_STOP));
    send_word(plain_word(rmpd_pkg::ACT_TICK));
    // zero duration takes the default frame count
    send_word(report_word(8'h0f, 8'd100, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd9));
    send_word(plain_word(rmpd_pkg::ACT_TICK));

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == 0) begin
        // all registers at their low end: zero frames hold, pin always on
        c.min_strength   = 8'd0;
        c.default_frames = 16'd0;
        c.min_frames     = 16'd0;
        c.rise_step      = 8'd1;
        c.fall_step      = 8'd1;
        c.kick_length    = 2'd0;
        c.full_on_level  = 8'd0;
      end else if (p == 1) begin
        c.min_strength   = 8'd255;
        c.default_frames = rmpd_pkg::CONTINUOUS_FRAMES;
        c.min_frames     = rmpd_pkg::MAX_FRAMES;
        c.rise_step      = 8'd255;
        c.fall_step      = 8'd255;
        c.kick_length    = 2'd3;
        c.full_on_level  = 8'd255;
      end else if (p == PHASE_COUNT - 1) begin
        c.min_strength   = rmpd_pkg::RST_MIN_STRENGTH;
        c.default_frames = rmpd_pkg::RST_DEFAULT_FRAMES;
        c.min_frames     = rmpd_pkg::RST_MIN_FRAMES;
        c.rise_step      = rmpd_pkg::RST_RISE_STEP;
        c.fall_step      = rmpd_pkg::RST_FALL_STEP;
        c.kick_length    = rmpd_pkg::RST_KICK_LENGTH;
        c.full_on_level  = rmpd_pkg::RST_FULL_ON_LEVEL;
      end else begin
        c.min_strength = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 70) c.default_frames = 16'($urandom_range(0, 40));
        else if (r < 80) c.default_frames = 16'd0;
        else if (r < 90) c.default_frames = rmpd_pkg::CONTINUOUS_FRAMES;
        else c.default_frames = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 4) != 0) c.min_frames = 16'($urandom_range(0, 12));
        else c.min_frames = 16'($urandom_range(0, 65534));
        c.rise_step   = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 40)) :
                                                      8'($urandom_range(1, 255));
        c.fall_step   = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 40)) :
                                                      8'($urandom_range(1, 255));
        c.kick_length = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 15) c.full_on_level = 8'd255;
        else if (r < 25) c.full_on_level = 8'($urandom_range(0, 40));
        else c.full_on_level = 8'($urandom_range(0, 255));
      end
      set_config(c);

      words  = 0;
      issued = 0;
      while (words < PHASE_WORDS) begin
        if (issued % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        // let every result drain before going on
        if (issued == 60) wait_drained();
        r = $urandom_range(0, 99);
        if (r < 55) w = plain_word(rmpd_pkg::ACT_TICK);
        else if (r < 89) w = random_report();
        else if (r < 94) w = plain_word(rmpd_pkg::ACT_STOP);
        else if (r < 97) w = plain_word(ACT_UNUSED);
        else begin
          w = random_report();
          w.payload_length = 8'($urandom_range(0, rmpd_pkg::REPORT_BYTES - 1));
        end
        send_word(w);
        issued = issued + 1;
        if (w.action != ACT_UNUSED &&
            !(w.action == rmpd_pkg::ACT_REPORT && w.payload_length < FULL_LEN))
          words = words + 1;
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (fail_count == 0 && pending_words == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
